FILE: rtl/lzsstd_pkg.sv
// Shared types and constants of the LZSS token decoder.
// Used by every module under rtl; no dependencies.
package lzsstd_pkg;

  // Shortest match length; the length code counts from here
  localparam int unsigned MIN_MATCH = 3;

  // Token queue between front and back
  localparam int unsigned CMDQ_DEPTH = 2;
  localparam int unsigned CMDQ_AW    = $clog2(CMDQ_DEPTH);

  // Result queue at the output, a power of two
  localparam int unsigned OUTQ_DEPTH = 4;
  localparam int unsigned OUTQ_AW    = $clog2(OUTQ_DEPTH);
  localparam int unsigned OUTQ_LW    = $clog2(OUTQ_DEPTH + 1);

  // Token class decided by the front
  typedef enum logic [1:0] {
    CMD_LIT    = 2'd0,
    CMD_BADPOS = 2'd1,
    CMD_COPY   = 2'd2
  } cmd_kind_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_POS  = 2'd1,
    ST_TOO_LONG = 2'd2
  } status_t;

  // Fixed-width part of a classified token
  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  lit;
  } cmd_head_t;

  // One result word
  typedef struct packed {
    logic [7:0]  data;
    logic        last;
    logic        done;
    status_t     status;
  } result_t;

  // Back engine states
  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_COPY = 2'b10
  } back_state_t;

endpackage

FILE: rtl/lzsstd_front.sv
// Front of the LZSS token decoder: accepts tokens, classifies them and
// holds them in a short queue for the back engine. Depends on lzsstd_pkg.
module lzsstd_front #(
  parameter int WINDOW_BITS = 13,
  parameter int LENGTH_BITS = 4
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      push,
  output logic                      full,
  input  logic                      literal_sel,
  input  logic [7:0]                literal_byte,
  input  logic [WINDOW_BITS-1:0]    match_position,
  input  logic [LENGTH_BITS-1:0]    match_length_code,
  output logic                      cmd_valid,
  input  logic                      cmd_take,
  output lzsstd_pkg::cmd_head_t     cmd_head,
  output logic [WINDOW_BITS-1:0]    cmd_src,
  output logic [LENGTH_BITS:0]      cmd_len
);

  localparam int AW = lzsstd_pkg::CMDQ_AW;
  localparam int CW = AW + 1;

  typedef struct packed {
    lzsstd_pkg::cmd_head_t       head;
    logic [WINDOW_BITS-1:0]      src;
    logic [LENGTH_BITS:0]        len;
  } entry_t;

  entry_t          q [lzsstd_pkg::CMDQ_DEPTH];
  entry_t          in_entry;
  logic [AW-1:0]   wp;
  logic [AW-1:0]   rp;
  logic [CW-1:0]   count;
  logic            do_push;
  logic            do_pop;

  // Classify the token; a zero position wins over any length check
  always_comb begin
    in_entry.head.lit = literal_byte;
    if (literal_sel) begin
      in_entry.head.kind = lzsstd_pkg::CMD_LIT;
    end else if (match_position == '0) begin
      in_entry.head.kind = lzsstd_pkg::CMD_BADPOS;
    end else begin
      in_entry.head.kind = lzsstd_pkg::CMD_COPY;
    end
    in_entry.src = match_position - WINDOW_BITS'(1);
    in_entry.len = (LENGTH_BITS + 1)'(match_length_code)
                 + (LENGTH_BITS + 1)'(lzsstd_pkg::MIN_MATCH);
  end

  assign full      = (count == CW'(lzsstd_pkg::CMDQ_DEPTH));
  assign cmd_valid = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = cmd_take && cmd_valid;

  assign cmd_head = q[rp].head;
  assign cmd_src  = q[rp].src;
  assign cmd_len  = q[rp].len;

  // Store classified tokens
  always_ff @(posedge clk) begin
    if (do_push) begin
      q[wp] <= in_entry;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wp <= wp + AW'(1);
      end
      if (do_pop) begin
        rp <= rp + AW'(1);
      end
      count <= count + CW'(do_push) - CW'(do_pop);
    end
  end

endmodule

FILE: rtl/lzsstd_back.sv
// Back engine of the LZSS token decoder: entry state, window memory and
// the byte copy sequencer. Depends on lzsstd_pkg.
module lzsstd_back #(
  parameter int WINDOW_BITS = 13,
  parameter int LENGTH_BITS = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic [31:0]                     cfg_data,
  input  logic                            cmd_valid,
  output logic                            cmd_take,
  input  lzsstd_pkg::cmd_head_t           cmd_head,
  input  logic [WINDOW_BITS-1:0]          cmd_src,
  input  logic [LENGTH_BITS:0]            cmd_len,
  input  logic [lzsstd_pkg::OUTQ_LW-1:0]  out_level,
  output logic                            out_push,
  output lzsstd_pkg::result_t             out_res
);

  localparam int WIN_SIZE = 1 << WINDOW_BITS;
  localparam int LVW      = lzsstd_pkg::OUTQ_LW + 1;

  // Window memory and its registered read data
  logic [7:0]                 window [WIN_SIZE];
  logic [7:0]                 rdata;

  // Entry state
  logic [31:0]                entry_length;
  logic [31:0]                issued, issued_next;
  logic                       failed, failed_next;
  lzsstd_pkg::back_state_t    state, state_next;
  logic [WINDOW_BITS-1:0]     src_ptr, src_ptr_next;
  logic [LENGTH_BITS:0]       left, left_next;

  // Write-back stage
  logic                       w_valid;
  logic                       w_direct;
  logic                       w_fwd;
  logic                       w_zero;
  logic                       w_wr;
  logic [WINDOW_BITS-1:0]     w_addr;
  lzsstd_pkg::result_t        w_res;
  logic [7:0]                 w_byte;
  logic [7:0]                 last_byte;

  // Load values for the write-back stage
  logic                       ld;
  logic                       ld_direct;
  logic                       ld_fwd;
  logic                       ld_zero;
  logic                       ld_wr;
  lzsstd_pkg::result_t        ld_res;

  logic                       issue_ok;
  logic                       rd_en;
  logic                       halted;
  logic                       too_long;
  logic                       done_now;
  logic [31:0]                remaining;

  // Reserve output space for the word in flight
  assign issue_ok = (LVW'(out_level) + LVW'(w_valid)) < LVW'(lzsstd_pkg::OUTQ_DEPTH);

  assign halted    = failed || (issued >= entry_length);
  assign remaining = entry_length - issued;
  assign too_long  = 32'(cmd_len) > remaining;
  assign done_now  = (issued + 32'd1) == entry_length;
  assign rd_en     = (state == lzsstd_pkg::B_COPY) && issue_ok;

  // Sequence tokens and copy bytes
  always_comb begin
    state_next   = state;
    issued_next  = issued;
    failed_next  = failed;
    src_ptr_next = src_ptr;
    left_next    = left;
    cmd_take     = 1'b0;
    ld           = 1'b0;
    ld_direct    = 1'b1;
    ld_fwd       = 1'b0;
    ld_zero      = 1'b0;
    ld_wr        = 1'b0;
    ld_res       = '{data: 8'd0, last: 1'b1, done: 1'b0, status: lzsstd_pkg::ST_OK};
    case (state)
      lzsstd_pkg::B_IDLE: begin
        if (cmd_valid && issue_ok) begin
          cmd_take = 1'b1;
          if (!halted) begin
            case (cmd_head.kind)
              lzsstd_pkg::CMD_LIT: begin
                ld          = 1'b1;
                ld_wr       = 1'b1;
                ld_res.data = cmd_head.lit;
                ld_res.done = done_now;
                issued_next = issued + 32'd1;
              end
              lzsstd_pkg::CMD_BADPOS: begin
                ld            = 1'b1;
                ld_res.status = lzsstd_pkg::ST_BAD_POS;
                failed_next   = 1'b1;
              end
              lzsstd_pkg::CMD_COPY: begin
                if (too_long) begin
                  ld            = 1'b1;
                  ld_res.status = lzsstd_pkg::ST_TOO_LONG;
                  failed_next   = 1'b1;
                end else begin
                  src_ptr_next = cmd_src;
                  left_next    = cmd_len;
                  state_next   = lzsstd_pkg::B_COPY;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      lzsstd_pkg::B_COPY: begin
        if (issue_ok) begin
          ld           = 1'b1;
          ld_direct    = 1'b0;
          ld_wr        = 1'b1;
          ld_fwd       = w_valid && w_wr && (w_addr == src_ptr);
          ld_zero      = (issued[31:WINDOW_BITS] == '0) && (32'(src_ptr) >= issued);
          ld_res.last  = (left == (LENGTH_BITS + 1)'(1));
          ld_res.done  = done_now;
          issued_next  = issued + 32'd1;
          src_ptr_next = src_ptr + WINDOW_BITS'(1);
          left_next    = left - (LENGTH_BITS + 1)'(1);
          if (left == (LENGTH_BITS + 1)'(1)) begin
            state_next = lzsstd_pkg::B_IDLE;
          end
        end
      end
      default: begin
        state_next = lzsstd_pkg::B_IDLE;
      end
    endcase
  end

  // Pick the byte of the write-back stage: literal, forwarded, unwritten or read
  always_comb begin
    if (w_direct) begin
      w_byte = w_res.data;
    end else if (w_fwd) begin
      w_byte = last_byte;
    end else if (w_zero) begin
      w_byte = 8'd0;
    end else begin
      w_byte = rdata;
    end
  end

  assign out_push = w_valid;
  always_comb begin
    out_res      = w_res;
    out_res.data = w_byte;
  end

  // Window read and write
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rdata <= window[src_ptr];
    end
    if (w_valid && w_wr) begin
      window[w_addr] <= w_byte;
    end
  end

  // Hold the last emitted byte for overlapping copies
  always_ff @(posedge clk) begin
    if (w_valid) begin
      last_byte <= w_byte;
    end
  end

  // Load the write-back stage payload
  always_ff @(posedge clk) begin
    if (ld) begin
      w_direct <= ld_direct;
      w_fwd    <= ld_fwd;
      w_zero   <= ld_zero;
      w_wr     <= ld_wr;
      w_addr   <= issued[WINDOW_BITS-1:0];
      w_res    <= ld_res;
    end
  end

  // Control state; a register write restarts the entry
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_length <= '0;
      issued       <= '0;
      failed       <= 1'b0;
      state        <= lzsstd_pkg::B_IDLE;
      w_valid      <= 1'b0;
      src_ptr      <= '0;
      left         <= '0;
    end else if (cfg_valid) begin
      entry_length <= cfg_data;
      issued       <= '0;
      failed       <= 1'b0;
      state        <= lzsstd_pkg::B_IDLE;
      w_valid      <= 1'b0;
    end else begin
      issued  <= issued_next;
      failed  <= failed_next;
      state   <= state_next;
      src_ptr <= src_ptr_next;
      left    <= left_next;
      w_valid <= ld;
    end
  end

endmodule

FILE: rtl/lzsstd_outq.sv
// Result queue of the LZSS token decoder: parts the back engine from the
// consumer and reports its fill level. Depends on lzsstd_pkg.
module lzsstd_outq (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_push,
  input  lzsstd_pkg::result_t             in_res,
  output logic [lzsstd_pkg::OUTQ_LW-1:0]  level,
  output logic                            empty,
  input  logic                            pop,
  output lzsstd_pkg::result_t             head
);

  localparam int AW = lzsstd_pkg::OUTQ_AW;
  localparam int LW = lzsstd_pkg::OUTQ_LW;

  lzsstd_pkg::result_t  q [lzsstd_pkg::OUTQ_DEPTH];
  logic [AW-1:0]        wp;
  logic [AW-1:0]        rp;
  logic                 do_pop;

  assign empty  = (level == '0);
  assign do_pop = pop && !empty;
  assign head   = q[rp];

  // Store words; the back engine never pushes into a full queue
  always_ff @(posedge clk) begin
    if (in_push) begin
      q[wp] <= in_res;
    end
  end

  // Advance pointers and level
  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      level <= '0;
    end else begin
      if (in_push) begin
        wp <= wp + AW'(1);
      end
      if (do_pop) begin
        rp <= rp + AW'(1);
      end
      level <= level + LW'(in_push) - LW'(do_pop);
    end
  end

endmodule

FILE: rtl/lzss_token_decoder.sv
// Top level of the LZSS token decoder: front queue, back engine, result queue.
// Depends on lzsstd_pkg, lzsstd_front, lzsstd_back and lzsstd_outq.
//
// Decodes parsed LZSS tokens into bytes against a window of 2**WINDOW_BITS
// bytes. A literal gives one byte; a match of n bytes (n = length code + 3,
// 3..18 by default) is dispatched from the idle state and then copied one
// byte per cycle while the result queue has room, paced by the single read
// port of the window memory; an error gives one word, a dropped token none.
// A literal or error word passes through the write-back stage register; a
// match first enters the B_COPY state. Results wait in a four-word queue,
// so the back engine runs up to four words ahead of the consumer, and a
// two-token front queue lets the token side run ahead of the back engine;
// once both are full the input stalls.
// Writing entry_length restarts the entry at once; the window needs no
// clearing pass, since bytes not yet written in this entry are tracked by the
// output count and read as zero. Write it only while no token is in flight.
module lzss_token_decoder #(
  parameter int WINDOW_BITS = 13,
  parameter int LENGTH_BITS = 4
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  output logic                    full,
  input  logic                    literal_sel,
  input  logic [7:0]              literal_byte,
  input  logic [WINDOW_BITS-1:0]  match_position,
  input  logic [LENGTH_BITS-1:0]  match_length_code,
  output logic                    empty,
  input  logic                    pop,
  output logic [7:0]              data_byte,
  output logic                    run_last,
  output logic                    entry_done,
  output logic [1:0]              status,
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [31:0]             cfg_data
);

  logic                            cmd_valid;
  logic                            cmd_take;
  lzsstd_pkg::cmd_head_t           cmd_head;
  logic [WINDOW_BITS-1:0]          cmd_src;
  logic [LENGTH_BITS:0]            cmd_len;
  logic [lzsstd_pkg::OUTQ_LW-1:0]  out_level;
  logic                            out_push;
  lzsstd_pkg::result_t             out_res;
  lzsstd_pkg::result_t             head;

  assign cfg_ready = 1'b1;

  lzsstd_front #(
    .WINDOW_BITS (WINDOW_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_front (
    .clk               (clk),
    .rst               (rst),
    .push              (push),
    .full              (full),
    .literal_sel       (literal_sel),
    .literal_byte      (literal_byte),
    .match_position    (match_position),
    .match_length_code (match_length_code),
    .cmd_valid         (cmd_valid),
    .cmd_take          (cmd_take),
    .cmd_head          (cmd_head),
    .cmd_src           (cmd_src),
    .cmd_len           (cmd_len)
  );

  lzsstd_back #(
    .WINDOW_BITS (WINDOW_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd_take  (cmd_take),
    .cmd_head  (cmd_head),
    .cmd_src   (cmd_src),
    .cmd_len   (cmd_len),
    .out_level (out_level),
    .out_push  (out_push),
    .out_res   (out_res)
  );

  lzsstd_outq u_outq (
    .clk     (clk),
    .rst     (rst),
    .in_push (out_push),
    .in_res  (out_res),
    .level   (out_level),
    .empty   (empty),
    .pop     (pop),
    .head    (head)
  );

  assign data_byte  = head.data;
  assign run_last   = head.last;
  assign entry_done = head.done;
  assign status     = head.status;

  // The back engine must never push into a full result queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    out_push |-> (out_level < lzsstd_pkg::OUTQ_LW'(lzsstd_pkg::OUTQ_DEPTH)))
    else $error("result queue overflow");

  // An error word closes its token and never completes the entry
  a_error_word: assert property (@(posedge clk) disable iff (rst)
    (out_push && (out_res.status != lzsstd_pkg::ST_OK))
      |-> (out_res.last && !out_res.done && (out_res.data == 8'd0)))
    else $error("malformed error word");

  // A token is taken only when room is reserved for its first word
  a_take_room: assert property (@(posedge clk) disable iff (rst)
    cmd_take |-> (out_level < lzsstd_pkg::OUTQ_LW'(lzsstd_pkg::OUTQ_DEPTH)))
    else $error("token taken without output room");

endmodule

FILE: sim/lzss_token_decoder_tb.sv
// Self-checking testbench for lzss_token_decoder: token stimulus, byte-level prediction.
// Depends on lzsstd_pkg (result_t, status_t, MIN_MATCH) and the lzss_token_decoder RTL.
`timescale 1ns / 1ps

module lzss_token_decoder_tb;

  localparam int WIN_BITS = 13;
  localparam int LEN_BITS = 4;
  localparam int WIN_SIZE = 1 << WIN_BITS;
  localparam int unsigned RANDOM_TOKENS = 305;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned MAX_REPORTS = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic push = 1'b0;
  logic full;
  logic literal_sel = 1'b0;
  logic [7:0] literal_byte = '0;
  logic [WIN_BITS-1:0] match_position = '0;
  logic [LEN_BITS-1:0] match_length_code = '0;
  logic empty;
  logic pop = 1'b0;
  logic [7:0] data_byte;
  logic run_last;
  logic entry_done;
  logic [1:0] status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [31:0] cfg_data = '0;

  // Decoder state as seen from outside
  logic [7:0] window_mem [WIN_SIZE];
  logic [31:0] out_count = '0;
  logic [31:0] entry_len = '0;
  logic entry_failed = 1'b0;
  lzsstd_pkg::result_t pending_words [$];

  // Run bookkeeping
  bit push_idle = 1'b1;
  bit pop_idle = 1'b1;
  int unsigned hold_left = 0;
  int unsigned pop_wait = 0;
  bit took_word = 1'b0;
  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned tokens_sent = 0;
  int unsigned live_tokens = 0;
  int unsigned words_checked = 0;
  int unsigned entries_run = 0;
  int unsigned stall_cycles = 0;

  lzss_token_decoder #(
    .WINDOW_BITS(WIN_BITS),
    .LENGTH_BITS(LEN_BITS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .push(push),
    .full(full),
    .literal_sel(literal_sel),
    .literal_byte(literal_byte),
    .match_position(match_position),
    .match_length_code(match_length_code),
    .empty(empty),
    .pop(pop),
    .data_byte(data_byte),
    .run_last(run_last),
    .entry_done(entry_done),
    .status(status),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycle_count,
               pending_words.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Append one expected word
  function automatic void queue_word(logic [7:0] b, logic last, logic done,
                                     lzsstd_pkg::status_t st);
    lzsstd_pkg::result_t w;
    w.data = b;
    w.last = last;
    w.done = done;
    w.status = st;
    pending_words.insert(pending_words.size(), w);
  endfunction

  // Decode one accepted token into the expected output words
  function automatic void decode_token(logic lit, logic [7:0] lb, logic [WIN_BITS-1:0] pos,
                                       logic [LEN_BITS-1:0] lcode);
    int unsigned run_len;
    logic [WIN_BITS-1:0] rd_addr;
    logic [7:0] b;
    // Finished or failed entries swallow every token
    if (entry_failed || out_count >= entry_len) return;
    live_tokens++;
    if (lit) begin
      window_mem[out_count[WIN_BITS-1:0]] = lb;
      out_count++;
      queue_word(lb, 1'b1, out_count == entry_len, lzsstd_pkg::ST_OK);
      return;
    end
    if (pos == '0) begin
      entry_failed = 1'b1;
      queue_word(8'h00, 1'b1, 1'b0, lzsstd_pkg::ST_BAD_POS);
      return;
    end
    run_len = lcode + lzsstd_pkg::MIN_MATCH;
    if (run_len > entry_len - out_count) begin
      entry_failed = 1'b1;
      queue_word(8'h00, 1'b1, 1'b0, lzsstd_pkg::ST_TOO_LONG);
      return;
    end
    // Copy byte by byte so overlapping runs see freshly written bytes
    rd_addr = pos - 1'b1;
    for (int unsigned i = 0; i < run_len; i++) begin
      b = window_mem[rd_addr];
      window_mem[out_count[WIN_BITS-1:0]] = b;
      out_count++;
      rd_addr++;
      queue_word(b, i + 1 == run_len, out_count == entry_len, lzsstd_pkg::ST_OK);
    end
  endfunction

  function automatic void report_mismatch(string what, lzsstd_pkg::result_t want,
                                          lzsstd_pkg::result_t got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t %s: want data %02h last %0b done %0b status %0d",
               $realtime, what, want.data, want.last, want.done, want.status);
      $display("    got data %02h last %0b done %0b status %0d",
               got.data, got.last, got.done, got.status);
    end
  endfunction

  // Check every word taken from the result side against the oldest expectation
  always @(posedge clk) begin
    lzsstd_pkg::result_t got;
    lzsstd_pkg::result_t want;
    took_word = 1'b0;
    if (!rst && push && full) stall_cycles++;
    if (!rst && pop && !empty) begin
      took_word = 1'b1;
      got.data = data_byte;
      got.last = run_last;
      got.done = entry_done;
      got.status = lzsstd_pkg::status_t'(status);
      if (pending_words.size() == 0) begin
        want = '0;
        report_mismatch("unexpected word", want, got);
      end else begin
        want = pending_words.pop_front();
        words_checked++;
        if (got.data !== want.data || got.last !== want.last || got.done !== want.done ||
            got.status !== want.status)
          report_mismatch("word mismatch", want, got);
      end
    end
  end

  // Drain the result side with random gaps and an optional long hold
  always @(negedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (took_word) pop_wait = pop_idle ? $urandom_range(0, 15) : 0;
      if (hold_left != 0) begin
        pop <= 1'b0;
        hold_left = hold_left - 1;
      end else if (pop_wait != 0) begin
        pop <= 1'b0;
        pop_wait = pop_wait - 1;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Offer one token after a random gap and hold it until accepted
  task automatic send_token(logic lit, logic [7:0] lb, logic [WIN_BITS-1:0] pos,
                            logic [LEN_BITS-1:0] lcode);
    int unsigned gap;
    gap = push_idle ? $urandom_range(0, 15) : 0;
    @(negedge clk);
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    push <= 1'b1;
    literal_sel <= lit;
    literal_byte <= lb;
    match_position <= pos;
    match_length_code <= lcode;
    @(posedge clk);
    while (full) @(posedge clk);
    tokens_sent++;
    decode_token(lit, lb, pos, lcode);
  endtask

  // Stop offering, wait for every expected word, then let dropped tokens retire
  task automatic wait_idle();
    @(negedge clk);
    push <= 1'b0;
    while (pending_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_entry_length(logic [31:0] len);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= len;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    entry_len = len;
    out_count = '0;
    entry_failed = 1'b0;
    foreach (window_mem[a]) window_mem[a] = 8'h00;
    entries_run++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // The block comes out of reset complete, and a zero length stays complete
  task automatic test_zero_length();
    send_token(1'b1, 8'h42, 13'd5, 4'd2);
    send_token(1'b0, 8'h00, 13'd1, 4'd0);
    wait_idle();
    write_entry_length(32'd0);
    send_token(1'b1, 8'hFF, 13'd0, 4'd0);
    send_token(1'b0, 8'h00, 13'd0, 4'd15);
    wait_idle();
  endtask

  // Literals, plain and overlapping copies, window wrap, overrun and drop after failure
  task automatic test_copy_runs();
    write_entry_length(32'd64);
    send_token(1'b1, 8'h00, 13'd8191, 4'd15);
    send_token(1'b1, 8'hFF, 13'd0, 4'd0);
    send_token(1'b1, 8'hA5, 13'd4096, 4'd8);
    send_token(1'b0, 8'hFF, 13'd1, 4'd0);
    send_token(1'b0, 8'h00, 13'd6, 4'd15);
    send_token(1'b0, 8'h55, 13'd8191, 4'd15);
    send_token(1'b1, 8'h3C, 13'd0, 4'd0);
    send_token(1'b0, 8'h00, 13'd43, 4'd15);
    send_token(1'b0, 8'h00, 13'd1, 4'd1);
    send_token(1'b1, 8'h11, 13'd0, 4'd0);
    wait_idle();
  endtask

  // Exact completion, then tokens past the end of the entry
  task automatic test_entry_end();
    write_entry_length(32'd5);
    send_token(1'b1, 8'h5A, 13'd0, 4'd0);
    send_token(1'b1, 8'hC3, 13'd0, 4'd0);
    send_token(1'b0, 8'h00, 13'd2, 4'd0);
    send_token(1'b1, 8'h99, 13'd0, 4'd0);
    send_token(1'b0, 8'h00, 13'd1, 4'd0);
    wait_idle();
  endtask

  // Zero position wins over overrun; overrun on a one-byte entry
  task automatic test_errors();
    write_entry_length(32'd10);
    send_token(1'b0, 8'h77, 13'd0, 4'd15);
    send_token(1'b1, 8'h01, 13'd0, 4'd0);
    wait_idle();
    write_entry_length(32'd1);
    send_token(1'b0, 8'h00, 13'd3, 4'd0);
    wait_idle();
  endtask

  // Fill the block while results are held, then pause until everything drains
  task automatic test_backpressure();
    write_entry_length(32'hFFFF_FFFF);
    push_idle = 1'b0;
    @(posedge clk);
    hold_left = HOLD_CYCLES;
    for (int i = 0; i < 30; i++) begin
      if (i % 3 == 0)
        send_token(1'b1, 8'($urandom_range(0, 255)), 13'd0, 4'd0);
      else
        send_token(1'b0, 8'h00, 13'($urandom_range(1, 16)), 4'($urandom_range(0, 15)));
    end
    wait_idle();
    send_token(1'b0, 8'h00, 13'd1, 4'd7);
    send_token(1'b1, 8'h7F, 13'd0, 4'd0);
    push_idle = 1'b1;
    wait_idle();
  endtask

  // Mostly well-formed tokens, with some broken ones; trailing noise follows in test_random_streams
  task automatic send_random_token();
    int unsigned rem;
    int unsigned pick;
    int unsigned top;
    logic [7:0] lb;
    logic [WIN_BITS-1:0] pos;
    logic [LEN_BITS-1:0] lc;
    lb = 8'($urandom_range(0, 255));
    pos = WIN_BITS'($urandom_range(0, WIN_SIZE - 1));
    lc = LEN_BITS'($urandom_range(0, 15));
    rem = entry_len - out_count;
    pick = $urandom_range(0, 99);
    if (pick < 3) begin
      send_token(1'b0, lb, '0, lc);
    end else if (pick < 8 && rem < 18) begin
      lc = LEN_BITS'($urandom_range(rem < 3 ? 0 : rem - 2, 15));
      if (pos == '0) pos = WIN_BITS'(1);
      send_token(1'b0, lb, pos, lc);
    end else if (pick < 45 || rem < 3) begin
      send_token(1'b1, lb, pos, lc);
    end else begin
      // Point mostly at bytes already written, sometimes anywhere in the window
      if (out_count != 0 && $urandom_range(0, 3) != 0)
        pos = WIN_BITS'($urandom_range(1, out_count < WIN_SIZE - 1 ? out_count : WIN_SIZE - 1));
      else if (pos == '0)
        pos = WIN_BITS'(1);
      top = (rem - 3 < 15) ? rem - 3 : 15;
      lc = LEN_BITS'($urandom_range(0, top));
      send_token(1'b0, lb, pos, lc);
    end
  endtask

  task automatic test_random_streams();
    int unsigned goal;
    int unsigned pick;
    logic [31:0] len;
    goal = live_tokens + RANDOM_TOKENS;
    while (live_tokens < goal) begin
      pick = $urandom_range(0, 7);
      if (pick == 0) len = $urandom_range(1, 3);
      else if (pick == 1) len = $urandom_range(400, 1500);
      else len = $urandom_range(8, 150);
      wait_idle();
      write_entry_length(len);
      push_idle = $urandom_range(0, 3) != 0;
      pop_idle = $urandom_range(0, 3) != 0;
      while (!entry_failed && out_count < entry_len && live_tokens < goal)
        send_random_token();
      repeat ($urandom_range(0, 2))
        send_token(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                   13'($urandom_range(0, WIN_SIZE - 1)), 4'($urandom_range(0, 15)));
    end
    push_idle = 1'b1;
    pop_idle = 1'b1;
    wait_idle();
  endtask

  initial begin
    foreach (window_mem[a]) window_mem[a] = 8'h00;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_zero_length();
    test_copy_runs();
    test_entry_end();
    test_errors();
    test_backpressure();
    test_random_streams();

    if (pending_words.size() != 0)
      $display("%0d expected words never arrived", pending_words.size());
    $display("%0d tokens accepted (%0d decoded) over %0d entries, %0d words checked",
             tokens_sent, live_tokens, entries_run, words_checked);
    $display("input held off for %0d cycles, %0d mismatches", stall_cycles, mismatch_count);
    if (mismatch_count == 0 && pending_words.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
